FILE: rtl/assert_macros.svh
// assertion macros used by the checker file est_checker.sv
// no dependencies; each macro expands to one labelled concurrent assertion
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is held
`define EST_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds across reset
`define EST_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/est_pkg.sv
// types, constants and the arctangent table of the euler scale transform
// no dependencies; imported by every datapath module of the block
`default_nettype none

package est_pkg;

  // datapath width of the cordic lanes (q.30 plus headroom)
  localparam int unsigned LW = 34;
  localparam int unsigned AW = 30;
  localparam int unsigned NUM_STEPS = 30;

  localparam logic signed [35:0] Q30_PI      = 36'sd3373259426;
  localparam logic signed [35:0] Q30_HALF_PI = 36'sd1686629713;
  localparam logic signed [35:0] Q30_TWO_PI  = 36'sd6746518852;
  localparam logic signed [LW-1:0] CORDIC_GAIN = 34'sd652032874;

  localparam logic [AW-1:0] ATAN_Q30 [0:NUM_STEPS-1] = '{
    30'h3243F6A8, 30'h1DAC6705, 30'h0FADBAFC, 30'h07F56EA6, 30'h03FEAB76, 30'h01FFD55B,
    30'h00FFFAAA, 30'h007FFF55, 30'h003FFFEA, 30'h001FFFFD, 30'h000FFFFF, 30'h0007FFFF,
    30'h0003FFFF, 30'h0001FFFF, 30'h0000FFFF, 30'h00007FFF, 30'h00003FFF, 30'h00001FFF,
    30'h00000FFF, 30'h000007FF, 30'h000003FF, 30'h000001FF, 30'h000000FF, 30'h0000007F,
    30'h0000003F, 30'h0000001F, 30'h0000000F, 30'h00000008, 30'h00000004, 30'h00000002
  };

  // lane index: 0 angle about y, 1 angle about x, 2 angle about z
  localparam int unsigned LANE_Y = 0;
  localparam int unsigned LANE_X = 1;
  localparam int unsigned LANE_Z = 2;

  typedef struct packed {
    logic signed [LW-1:0] x;
    logic signed [LW-1:0] y;
    logic signed [LW-1:0] z;
    logic                 neg;
  } lane_t;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic signed [15:0] sx;
    logic signed [15:0] sy;
    logic signed [15:0] sz;
  } side_t;

  typedef struct packed {
    lane_t [2:0] lane;
    side_t       side;
  } cdata_t;

  typedef struct packed {
    logic signed [31:0] r00;
    logic signed [31:0] r01;
    logic signed [31:0] r02;
    logic signed [31:0] r10;
    logic signed [31:0] r11;
    logic signed [31:0] r12;
    logic signed [31:0] r20;
    logic signed [31:0] r21;
    logic signed [31:0] r22;
    logic signed [31:0] tx;
    logic signed [31:0] ty;
    logic signed [31:0] tz;
  } res_t;

endpackage

`default_nettype wire

FILE: rtl/euler_scale_transform_3d_core.sv
// top level of the y-x-z euler angle model matrix with per-row scale
// depends on est_pkg, est_prep, est_cell and est_matrix
//
//   channel | handshake           | payload
//   --------+---------------------+---------------------------------------------
//   in      | in_valid / in_stall | position xyz q16.16, angles q4.12, scales q8.8
//   out     | out_valid/out_stall | nine rotation-scale entries, shift xyz q16.16
//
// one transfer per cycle sustained while out_stall is low; one wrap/fold stage,
// thirty cordic cells (one rotation each, all three angles side by side) and
// seven back-end stages ending in the output register
// synchronous active-low reset clears every stage valid bit, payload is not reset
// each stage loads while it is empty or its successor moves, so bubbles close up
// and new transfers are taken while a result waits; in_stall rises only once
// every stage holds an item and out_stall is high
`default_nettype none

module euler_scale_transform_3d_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_position_x,
  input  logic signed [31:0] in_position_y,
  input  logic signed [31:0] in_position_z,
  input  logic signed [15:0] in_angle_about_x,
  input  logic signed [15:0] in_angle_about_y,
  input  logic signed [15:0] in_angle_about_z,
  input  logic signed [15:0] in_scale_x,
  input  logic signed [15:0] in_scale_y,
  input  logic signed [15:0] in_scale_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_row0_col0,
  output logic signed [31:0] out_row0_col1,
  output logic signed [31:0] out_row0_col2,
  output logic signed [31:0] out_row1_col0,
  output logic signed [31:0] out_row1_col1,
  output logic signed [31:0] out_row1_col2,
  output logic signed [31:0] out_row2_col0,
  output logic signed [31:0] out_row2_col1,
  output logic signed [31:0] out_row2_col2,
  output logic signed [31:0] out_shift_x,
  output logic signed [31:0] out_shift_y,
  output logic signed [31:0] out_shift_z
);
  import est_pkg::*;

  // cordic chain links: index 0 leaves the entry stage, NUM_STEPS enters the back end
  cdata_t              link_data [NUM_STEPS+1];
  logic [NUM_STEPS:0]  link_valid;
  logic [NUM_STEPS:0]  link_ready;
  logic                prep_ready;
  side_t               side_in;
  res_t                res;

  // translation and scales ride alongside the angles through the chain
  assign side_in.px = in_position_x;
  assign side_in.py = in_position_y;
  assign side_in.pz = in_position_z;
  assign side_in.sx = in_scale_x;
  assign side_in.sy = in_scale_y;
  assign side_in.sz = in_scale_z;

  // angle wrap by two pi and fold by pi, fold sign carried to the back end
  est_prep u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (prep_ready),
    .ang_y     (in_angle_about_y),
    .ang_x     (in_angle_about_x),
    .ang_z     (in_angle_about_z),
    .side      (side_in),
    .out_valid (link_valid[0]),
    .out_ready (link_ready[0]),
    .dout      (link_data[0])
  );

  assign in_stall = !prep_ready;

  // row of identical rotation cells, step i shifts by i
  for (genvar i = 0; i < NUM_STEPS; i++) begin : g_cell
    est_cell #(.STEP(i)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (link_valid[i]),
      .in_ready  (link_ready[i]),
      .din       (link_data[i]),
      .out_valid (link_valid[i+1]),
      .out_ready (link_ready[i+1]),
      .dout      (link_data[i+1])
    );
  end

  // products, row sums, scaling and the output register
  est_matrix u_matrix (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (link_valid[NUM_STEPS]),
    .in_ready  (link_ready[NUM_STEPS]),
    .din       (link_data[NUM_STEPS]),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res       (res)
  );

  assign out_row0_col0 = res.r00;
  assign out_row0_col1 = res.r01;
  assign out_row0_col2 = res.r02;
  assign out_row1_col0 = res.r10;
  assign out_row1_col1 = res.r11;
  assign out_row1_col2 = res.r12;
  assign out_row2_col0 = res.r20;
  assign out_row2_col1 = res.r21;
  assign out_row2_col2 = res.r22;
  assign out_shift_x   = res.tx;
  assign out_shift_y   = res.ty;
  assign out_shift_z   = res.tz;

endmodule

`default_nettype wire

FILE: rtl/est_prep.sv
// entry stage: angle wrap into [-pi, pi] and fold into [-pi/2, pi/2]
// depends on est_pkg
`default_nettype none

module est_prep (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [15:0]  ang_y,
  input  logic signed [15:0]  ang_x,
  input  logic signed [15:0]  ang_z,
  input  est_pkg::side_t      side,
  output logic                out_valid,
  input  logic                out_ready,
  output est_pkg::cdata_t     dout
);
  import est_pkg::*;

  logic   valid_r, valid_nxt;
  cdata_t data_r, data_nxt;
  logic signed [15:0] ang [3];

  function automatic lane_t prep_lane(input logic signed [15:0] a);
    logic signed [35:0] z0;
    logic signed [35:0] z1;
    logic signed [35:0] z2;
    lane_t              l;
    z0 = {{2{a[15]}}, a, 18'b0};
    if (z0 > Q30_PI)       z1 = z0 - Q30_TWO_PI;
    else if (z0 < -Q30_PI) z1 = z0 + Q30_TWO_PI;
    else                   z1 = z0;
    l.neg = 1'b1;
    if (z1 > Q30_HALF_PI)       z2 = z1 - Q30_PI;
    else if (z1 < -Q30_HALF_PI) z2 = z1 + Q30_PI;
    else begin
      z2    = z1;
      l.neg = 1'b0;
    end
    l.x = CORDIC_GAIN;
    l.y = '0;
    l.z = z2[LW-1:0];
    return l;
  endfunction

  assign ang[LANE_Y] = ang_y;
  assign ang[LANE_X] = ang_x;
  assign ang[LANE_Z] = ang_z;

  assign in_ready  = !valid_r || out_ready;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_comb begin
    data_nxt.side = side;
    for (int l = 0; l < 3; l++) begin
      data_nxt.lane[l] = prep_lane(ang[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else        valid_r <= valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (in_ready) data_r <= data_nxt;
  end

  assign out_valid = valid_r;
  assign dout      = data_r;

endmodule

`default_nettype wire

FILE: rtl/est_cell.sv
// one cordic rotation step for all three angles, registered
// depends on est_pkg
`default_nettype none

module est_cell #(
  parameter int unsigned STEP = 0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  est_pkg::cdata_t din,
  output logic            out_valid,
  input  logic            out_ready,
  output est_pkg::cdata_t dout
);
  import est_pkg::*;

  localparam logic signed [LW-1:0] ATAN = $signed({{(LW-AW){1'b0}}, ATAN_Q30[STEP]});

  logic   valid_r, valid_nxt;
  cdata_t data_r, data_nxt;

  assign in_ready  = !valid_r || out_ready;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_comb begin
    logic signed [LW-1:0] x;
    logic signed [LW-1:0] y;
    logic signed [LW-1:0] z;
    data_nxt = din;
    for (int l = 0; l < 3; l++) begin
      x = din.lane[l].x;
      y = din.lane[l].y;
      z = din.lane[l].z;
      if (!z[LW-1]) begin
        data_nxt.lane[l].x = x - (y >>> STEP);
        data_nxt.lane[l].y = y + (x >>> STEP);
        data_nxt.lane[l].z = z - ATAN;
      end else begin
        data_nxt.lane[l].x = x + (y >>> STEP);
        data_nxt.lane[l].y = y - (x >>> STEP);
        data_nxt.lane[l].z = z + ATAN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else        valid_r <= valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (in_ready) data_r <= data_nxt;
  end

  assign out_valid = valid_r;
  assign dout      = data_r;

endmodule

`default_nettype wire

FILE: rtl/est_matrix.sv
// back end: fold correction, products, row sums, row scale, output register
// depends on est_pkg
`default_nettype none

module est_matrix (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  est_pkg::cdata_t din,
  output logic            out_valid,
  input  logic            out_stall,
  output est_pkg::res_t   res
);
  import est_pkg::*;

  localparam int unsigned NST = 7;

  logic [NST-1:0] valid_r, valid_nxt;
  logic [NST-1:0] rdy;

  // stage 0: sine and cosine with fold sign applied
  logic signed [31:0] s1_r, c1_r, s2_r, c2_r, s3_r, c3_r;
  side_t              sd0_r;
  // stage 1: raw first products
  logic signed [63:0] m_r [10];
  logic signed [31:0] s2a_r, s3a_r;
  side_t              sd1_r;
  // stage 2: rounded first products
  logic signed [31:0] q_r [10];
  logic signed [31:0] s2b_r, s3b_r;
  side_t              sd2_r;
  // stage 3: raw three-term products
  logic signed [63:0] t_r [4];
  logic signed [31:0] qc_r [10];
  logic signed [31:0] s2c_r;
  side_t              sd3_r;
  // stage 4: matrix entries in q.30
  logic signed [32:0] e_r [9];
  side_t              sd4_r;
  // stage 5: raw scaled entries
  logic signed [48:0] f_r [9];
  side_t              sd5_r;
  // stage 6: output register
  res_t               res_r;

  localparam int unsigned C1C3 = 0, S1S2 = 1, C1S2 = 2, C3S1 = 3, C1S3 = 4;
  localparam int unsigned S1S3 = 5, C2S3 = 6, C2C3 = 7, C2S1 = 8, C1C2 = 9;

  function automatic logic signed [31:0] fix_sign(input logic signed [LW-1:0] v,
                                                  input logic neg);
    logic signed [LW-1:0] n;
    n = neg ? -v : v;
    return n[31:0];
  endfunction

  function automatic logic signed [31:0] rnd30(input logic signed [63:0] m);
    logic signed [63:0] t;
    t = m + 64'sd536870912;
    return t[61:30];
  endfunction

  function automatic logic signed [32:0] ext33(input logic signed [31:0] v);
    return {v[31], v};
  endfunction

  // q16.16 result always lies inside the signed 32-bit range, so the clamp
  // reduces to sign extension of the 28-bit rounded value
  function automatic logic signed [31:0] rnd22(input logic signed [48:0] f);
    logic signed [49:0] t;
    t = {f[48], f} + 50'sd2097152;
    return {{4{t[49]}}, t[49:22]};
  endfunction

  always_comb begin
    rdy[NST-1] = !valid_r[NST-1] || !out_stall;
    for (int k = NST-2; k >= 0; k--) begin
      rdy[k] = !valid_r[k] || rdy[k+1];
    end
    valid_nxt[0] = rdy[0] ? in_valid : valid_r[0];
    for (int k = 1; k < NST; k++) begin
      valid_nxt[k] = rdy[k] ? valid_r[k-1] : valid_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= '0;
    else        valid_r <= valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      s1_r  <= fix_sign(din.lane[LANE_Y].y, din.lane[LANE_Y].neg);
      c1_r  <= fix_sign(din.lane[LANE_Y].x, din.lane[LANE_Y].neg);
      s2_r  <= fix_sign(din.lane[LANE_X].y, din.lane[LANE_X].neg);
      c2_r  <= fix_sign(din.lane[LANE_X].x, din.lane[LANE_X].neg);
      s3_r  <= fix_sign(din.lane[LANE_Z].y, din.lane[LANE_Z].neg);
      c3_r  <= fix_sign(din.lane[LANE_Z].x, din.lane[LANE_Z].neg);
      sd0_r <= din.side;
    end
    if (rdy[1]) begin
      m_r[C1C3] <= c1_r * c3_r;
      m_r[S1S2] <= s1_r * s2_r;
      m_r[C1S2] <= c1_r * s2_r;
      m_r[C3S1] <= c3_r * s1_r;
      m_r[C1S3] <= c1_r * s3_r;
      m_r[S1S3] <= s1_r * s3_r;
      m_r[C2S3] <= c2_r * s3_r;
      m_r[C2C3] <= c2_r * c3_r;
      m_r[C2S1] <= c2_r * s1_r;
      m_r[C1C2] <= c1_r * c2_r;
      s2a_r     <= s2_r;
      s3a_r     <= s3_r;
      sd1_r     <= sd0_r;
    end
    if (rdy[2]) begin
      for (int i = 0; i < 10; i++) q_r[i] <= rnd30(m_r[i]);
      s2b_r <= s2a_r;
      s3b_r <= s3a_r;
      sd2_r <= sd1_r;
    end
    if (rdy[3]) begin
      t_r[0] <= q_r[S1S2] * s3b_r;
      t_r[1] <= q_r[C1S2] * s3b_r;
      t_r[2] <= q_r[C3S1] * s2b_r;
      t_r[3] <= q_r[C1C3] * s2b_r;
      qc_r   <= q_r;
      s2c_r  <= s2b_r;
      sd3_r  <= sd2_r;
    end
    if (rdy[4]) begin
      e_r[0] <= ext33(qc_r[C1C3]) + ext33(rnd30(t_r[0]));
      e_r[1] <= ext33(qc_r[C2S3]);
      e_r[2] <= ext33(rnd30(t_r[1])) - ext33(qc_r[C3S1]);
      e_r[3] <= ext33(rnd30(t_r[2])) - ext33(qc_r[C1S3]);
      e_r[4] <= ext33(qc_r[C2C3]);
      e_r[5] <= ext33(rnd30(t_r[3])) + ext33(qc_r[S1S3]);
      e_r[6] <= ext33(qc_r[C2S1]);
      e_r[7] <= -ext33(s2c_r);
      e_r[8] <= ext33(qc_r[C1C2]);
      sd4_r  <= sd3_r;
    end
    if (rdy[5]) begin
      for (int i = 0; i < 3; i++) f_r[i] <= e_r[i] * sd4_r.sx;
      for (int i = 3; i < 6; i++) f_r[i] <= e_r[i] * sd4_r.sy;
      for (int i = 6; i < 9; i++) f_r[i] <= e_r[i] * sd4_r.sz;
      sd5_r <= sd4_r;
    end
    if (rdy[6]) begin
      res_r.r00 <= rnd22(f_r[0]);
      res_r.r01 <= rnd22(f_r[1]);
      res_r.r02 <= rnd22(f_r[2]);
      res_r.r10 <= rnd22(f_r[3]);
      res_r.r11 <= rnd22(f_r[4]);
      res_r.r12 <= rnd22(f_r[5]);
      res_r.r20 <= rnd22(f_r[6]);
      res_r.r21 <= rnd22(f_r[7]);
      res_r.r22 <= rnd22(f_r[8]);
      res_r.tx  <= sd5_r.px;
      res_r.ty  <= sd5_r.py;
      res_r.tz  <= sd5_r.pz;
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = valid_r[NST-1];
  assign res       = res_r;

endmodule

`default_nettype wire

FILE: rtl/est_checker.sv
// port-level checks of the euler scale transform and their bind
// depends on assert_macros.svh and the top level's ports
`default_nettype none
`include "assert_macros.svh"

module est_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] out_shift_x
);

  // input side can only back up when the whole pipe is full and blocked
  `EST_ASSERT(a_stall_only_full, in_stall |-> (out_valid && out_stall), "input stalled while output free")
  // reset empties the output register
  `EST_ASSERT_RST(a_reset_clears, !rst_n |=> !out_valid, "result present after reset")
  // a blocked result is not dropped, and its x shift does not change
  `EST_ASSERT(a_hold_valid, (out_valid && out_stall) |=> out_valid, "blocked result dropped")
  `EST_ASSERT(a_hold_data, (out_valid && out_stall) |=> $stable(out_shift_x), "blocked result changed")

endmodule

bind euler_scale_transform_3d_core est_checker u_est_checker (.*);

`default_nettype wire
